>>> src/base_pair_distance_top_defines.svh
// Assertion macros shared by the base-pair distance RTL.
`ifndef BASE_PAIR_DISTANCE_TOP_DEFINES_SVH
`define BASE_PAIR_DISTANCE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BPD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BPD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define BPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BPD_ASSERT(lbl, clk, rstn, prop, msg)
`define BPD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define BPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> src/bpd_pkg.sv
`default_nettype none

package bpd_pkg;

    localparam int SYM_W     = 2;
    localparam int DIST_W    = 11;
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [SYM_W-1:0] SYM_OPEN  = 2'd0;
    localparam logic [SYM_W-1:0] SYM_CLOSE = 2'd1;
    localparam logic [SYM_W-1:0] SYM_DOT   = 2'd2;
    localparam logic [SYM_W-1:0] SYM_BAD   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNCLOSED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd4;

    localparam logic [DIST_W-1:0] DIST_MAX = 11'd2047;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_cmd_t;

endpackage

`default_nettype wire

>>> src/bpd_stack.sv
`default_nettype none
`include "base_pair_distance_top_defines.svh"

module bpd_stack import bpd_pkg::*; #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH),
    localparam int DW = $clog2(DEPTH + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire stack_cmd_t    cmd,
    input  wire logic [AW-1:0] push_data,
    output logic      [AW-1:0] top,
    output logic      [DW-1:0] depth
);

    // Top entry lives in top_reg; entries below it live in the memory.
    // The entry under the top is prefetched every cycle so pops can follow
    // each other back to back.
    logic [AW-1:0] mem [DEPTH];

    logic [DW-1:0] depth_reg;
    logic [DW-1:0] depth_next;
    logic [AW-1:0] top_reg;
    logic [AW-1:0] top_next;
    logic [AW-1:0] rd_data_reg;
    logic [AW-1:0] byp_data_reg;
    logic          byp_valid_reg;
    logic [DW-1:0] depth_m1;
    logic [DW-1:0] depth_m2;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] second;

    always_comb begin
        priority if (cmd.clear) begin
            depth_next = '0;
        end else if (cmd.push) begin
            depth_next = depth_reg + DW'(1);
        end else if (cmd.pop) begin
            depth_next = depth_reg - DW'(1);
        end else begin
            depth_next = depth_reg;
        end
    end

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_next - DW'(2);
    assign wr_addr  = depth_m1[AW-1:0];
    assign rd_addr  = depth_m2[AW-1:0];
    assign wr_en    = cmd.push && (depth_reg != '0);
    assign second   = byp_valid_reg ? byp_data_reg : rd_data_reg;

    always_comb begin
        priority if (cmd.push) begin
            top_next = push_data;
        end else if (cmd.pop) begin
            top_next = second;
        end else begin
            top_next = top_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= top_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Read of the address being written this cycle takes the written value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end else begin
            depth_reg     <= depth_next;
            byp_valid_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        byp_data_reg <= top_reg;
    end

    assign top   = top_reg;
    assign depth = depth_reg;

    `BPD_ASSERT(a_push_pop_excl, aclk, aresetn, !(cmd.push && cmd.pop), "push and pop together")
    `BPD_ASSERT_IMPL(a_pop_nonempty, aclk, aresetn, cmd.pop, depth_reg != '0, "pop on empty")
    `BPD_ASSERT_IMPL(a_push_room, aclk, aresetn, cmd.push, depth_reg < DW'(DEPTH), "push on full")
    `BPD_ASSERT_NEXT(a_clear_empty, aclk, aresetn, cmd.clear, depth_reg == '0, "clear kept depth")

endmodule

`default_nettype wire

>>> src/base_pair_distance_top.sv
`default_nettype none
`include "base_pair_distance_top_defines.svh"

// Base-pair distance of two dot-bracket structures streamed side by side,
// one position (a symbol of each) per item; the item with tlast closes the
// pair and yields one result {status, distance}, after which all state is
// cleared for the next pair. The block takes one item every clock cycle:
// each stack does at most one push or pop per item, with its top held in a
// register and the entry below it prefetched from a MAX_LEN-entry memory
// (one write and one read port), so pops and pushes may follow in any order.
// Only an item with tlast can wait, and only while the previous result is
// still unread. A result is registered: its item is held in the input
// register, and the result is written to the output register when that item advances.
// Structures longer than MAX_LEN positions report status 4 (too long), unless an earlier error stuck.
module base_pair_distance_top import bpd_pkg::*; #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [1:0] sym_a, [3:2] sym_b, zero fill
    input  wire logic                 s_tlast,  // last position of both structures
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata   // [10:0] distance, [13:11] status, zero fill
);

    localparam int PW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = (CW + 1 > DIST_W) ? CW + 1 : DIST_W;

    // input register
    logic             in_valid_reg;
    logic [SYM_W-1:0] in_sym_a_reg;
    logic [SYM_W-1:0] in_sym_b_reg;
    logic             in_last_reg;

    // result register
    logic                out_valid_reg;
    logic [DIST_W-1:0]   out_dist_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [DIST_W-1:0]   out_dist_next;
    logic [STATUS_W-1:0] out_status_next;

    // per-pair state
    logic [CW-1:0]       pos_reg;
    logic [CW-1:0]       pos_next;
    logic [CW-1:0]       pairs_a_reg;
    logic [CW-1:0]       pairs_a_next;
    logic [CW-1:0]       pairs_b_reg;
    logic [CW-1:0]       pairs_b_next;
    logic [CW-1:0]       common_reg;
    logic [CW-1:0]       common_next;
    logic [STATUS_W-1:0] err_reg;
    logic [STATUS_W-1:0] err_next;

    logic          advance;
    logic          too_long;
    logic          bad_sym;
    logic          unmatched;
    logic          work;
    logic          hit_common;
    logic          clear;
    stack_cmd_t    cmd_a;
    stack_cmd_t    cmd_b;
    logic [PW-1:0] top_a;
    logic [PW-1:0] top_b;
    logic [CW-1:0] depth_a;
    logic [CW-1:0] depth_b;
    logic [CW-1:0] depth_a_after;
    logic [CW-1:0] depth_b_after;
    logic [SW-1:0] dist_full;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sym_a_reg <= s_tdata[SYM_W-1:0];
            in_sym_b_reg <= s_tdata[2*SYM_W-1:SYM_W];
            in_last_reg  <= s_tlast;
        end
    end

    // checks in order of precedence; the first error of a pair sticks
    assign too_long  = (pos_reg == CW'(MAX_LEN));
    assign bad_sym   = (in_sym_a_reg == SYM_BAD) || (in_sym_b_reg == SYM_BAD);
    assign unmatched = ((in_sym_a_reg == SYM_CLOSE) && (depth_a == '0))
                    || ((in_sym_b_reg == SYM_CLOSE) && (depth_b == '0));
    assign work      = (err_reg == ST_OK) && !too_long && !bad_sym && !unmatched;

    always_comb begin
        priority if (err_reg != ST_OK) begin
            err_next = err_reg;
        end else if (too_long) begin
            err_next = ST_TOO_LONG;
        end else if (bad_sym) begin
            err_next = ST_INVALID;
        end else if (unmatched) begin
            err_next = ST_UNMATCHED;
        end else begin
            err_next = ST_OK;
        end
    end

    assign clear = advance && in_last_reg;

    assign cmd_a.push  = advance && work && (in_sym_a_reg == SYM_OPEN);
    assign cmd_a.pop   = advance && work && (in_sym_a_reg == SYM_CLOSE);
    assign cmd_a.clear = clear;
    assign cmd_b.push  = advance && work && (in_sym_b_reg == SYM_OPEN);
    assign cmd_b.pop   = advance && work && (in_sym_b_reg == SYM_CLOSE);
    assign cmd_b.clear = clear;

    assign hit_common = cmd_a.pop && cmd_b.pop && (top_a == top_b);

    assign pairs_a_next = pairs_a_reg + CW'(cmd_a.pop);
    assign pairs_b_next = pairs_b_reg + CW'(cmd_b.pop);
    assign common_next  = common_reg + CW'(hit_common);
    assign pos_next     = too_long ? pos_reg : pos_reg + CW'(1);

    assign depth_a_after = depth_a + CW'(cmd_a.push) - CW'(cmd_a.pop);
    assign depth_b_after = depth_b + CW'(cmd_b.push) - CW'(cmd_b.pop);

    assign dist_full = SW'(pairs_a_next) + SW'(pairs_b_next) - (SW'(common_next) << 1);

    always_comb begin
        out_status_next = err_next;
        if ((err_next == ST_OK) && ((depth_a_after != '0) || (depth_b_after != '0))) begin
            out_status_next = ST_UNCLOSED;
        end
        if (out_status_next != ST_OK) begin
            out_dist_next = '0;
        end else if (dist_full > SW'(DIST_MAX)) begin
            out_dist_next = DIST_MAX;
        end else begin
            out_dist_next = dist_full[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            pairs_a_reg <= '0;
            pairs_b_reg <= '0;
            common_reg  <= '0;
            err_reg     <= ST_OK;
        end else if (clear) begin
            pos_reg     <= '0;
            pairs_a_reg <= '0;
            pairs_b_reg <= '0;
            common_reg  <= '0;
            err_reg     <= ST_OK;
        end else if (advance) begin
            pos_reg     <= pos_next;
            pairs_a_reg <= pairs_a_next;
            pairs_b_reg <= pairs_b_next;
            common_reg  <= common_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (clear) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            out_dist_reg   <= out_dist_next;
            out_status_reg <= out_status_next;
        end
    end

    bpd_stack #(.DEPTH(MAX_LEN)) u_stack_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd_a),
        .push_data (pos_reg[PW-1:0]),
        .top       (top_a),
        .depth     (depth_a)
    );

    bpd_stack #(.DEPTH(MAX_LEN)) u_stack_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd_b),
        .push_data (pos_reg[PW-1:0]),
        .top       (top_b),
        .depth     (depth_b)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - DIST_W - STATUS_W){1'b0}}, out_status_reg, out_dist_reg};

    `BPD_ASSERT_IMPL(a_err_dist_zero, aclk, aresetn,
        out_valid_reg && (out_status_reg != ST_OK), out_dist_reg == '0,
        "error result with distance")
    `BPD_ASSERT(a_pos_bound, aclk, aresetn, pos_reg <= CW'(MAX_LEN), "position past limit")
    `BPD_ASSERT(a_common_bound, aclk, aresetn,
        (common_reg <= pairs_a_reg) && (common_reg <= pairs_b_reg), "common exceeds pairs")
    `BPD_ASSERT_NEXT(a_last_clears, aclk, aresetn, clear,
        (pos_reg == '0) && (err_reg == ST_OK) && out_valid_reg, "last item did not clear")

endmodule

`default_nettype wire
